### hdl/grr_pkg.sv
package grr_pkg;

  // Deepest group the store can hold.
  localparam int MaxGroup = 16;
  localparam int AddrW    = $clog2(MaxGroup);
  localparam int CntW     = $clog2(MaxGroup + 1);
  localparam int GsW      = 5;

  typedef struct packed {
    logic signed [31:0] value;
    logic               final_element;
  } grr_in_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               run_last;
    logic               sequence_end;
  } grr_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               wr_en;
    logic [AddrW-1:0]   wr_addr;
    logic               rd_en;
    logic [AddrW-1:0]   rd_addr;
    logic               rd_last;
    logic               rd_end;
  } grr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } grr_sts_t;

endpackage

### hdl/grr_dpath.sv
module grr_dpath import grr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  grr_cmd_t          cmd_i,
  output grr_sts_t          sts_o,
  input  grr_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output grr_out_t          out_data_o
);

  logic signed [31:0] store_q [MaxGroup];
  logic               out_valid_q, out_valid_d;
  grr_out_t           out_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store_q[cmd_i.wr_addr] <= in_data_i.value;
    end
  end

  // The output register doubles as the registered read port of the store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      out_data_q.value_res    <= store_q[cmd_i.rd_addr];
      out_data_q.run_last     <= cmd_i.rd_last;
      out_data_q.sequence_end <= cmd_i.rd_end;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.rd_en) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

### hdl/grr_ctrl.sv
module grr_ctrl import grr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           in_final_i,
  input  logic           cfg_we_i,
  input  logic [GsW-1:0] cfg_wdata_i,
  input  grr_sts_t       sts_i,
  output grr_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } grr_state_e;

  grr_state_e       state_q, state_d;
  logic [GsW-1:0]   group_size_q;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] last_idx_q, last_idx_d;
  logic             rev_q, rev_d;
  logic             fin_q, fin_d;
  logic [CntW-1:0]  k_eff;
  logic [AddrW-1:0] wr_addr;
  logic [CntW-1:0]  n_new;

  always_comb begin
    if (group_size_q == '0) begin
      k_eff = CntW'(1);
    end else if (int'(group_size_q) > MaxGroup) begin
      k_eff = CntW'(MaxGroup);
    end else begin
      k_eff = CntW'(group_size_q);
    end
  end

  assign wr_addr = (int'(fill_q) >= MaxGroup) ? AddrW'(MaxGroup - 1) : fill_q[AddrW-1:0];
  assign n_new   = CntW'(wr_addr) + CntW'(1);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    last_idx_d = last_idx_q;
    rev_d      = rev_q;
    fin_d      = fin_q;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = wr_addr;
          if (n_new >= k_eff || in_final_i) begin
            // A full group drains reversed; a short tail at the end keeps its order.
            state_d    = ST_DRAIN;
            rev_d      = (n_new >= k_eff);
            fin_d      = in_final_i;
            last_idx_d = wr_addr;
            cnt_d      = '0;
            fill_d     = '0;
          end else begin
            fill_d = n_new;
          end
        end
      end
      ST_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = rev_q ? (last_idx_q - cnt_q) : cnt_q;
          cmd_o.rd_last = (cnt_q == last_idx_q);
          cmd_o.rd_end  = (cnt_q == last_idx_q) && fin_q;
          cnt_d         = cnt_q + AddrW'(1);
          if (cnt_q == last_idx_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      group_size_q <= GsW'(2);
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    last_idx_q <= last_idx_d;
    rev_q      <= rev_d;
    fin_q      <= fin_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

### hdl/group_reverse_reorder_unit.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o   in_data_i (grr_in_t)
// out       output     out_valid_o/out_stall_i out_data_o (grr_out_t)
// cfg       input      cfg_we_i                cfg_wdata_i (group size)
//
// An element is taken while the unit is idle. An element that completes a group, or ends
// the sequence, is followed by a drain of its group, one result a cycle while the output
// is free, from the single read port of the group store.
// Requests are stalled for the whole drain. A stalled output holds the drain.
// Reset clears the fill count and the output valid and sets the group size to 2;
// the group store itself is not cleared.
module group_reverse_reorder_unit import grr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  grr_in_t        in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output grr_out_t       out_data_o,
  input  logic           cfg_we_i,
  input  logic [GsW-1:0] cfg_wdata_i
);

  grr_cmd_t cmd;
  grr_sts_t sts;

  grr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_final_i  (in_data_i.final_element),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  grr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A read must only land in a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.rd_en |-> sts.out_free)
    else $error("store read while output register occupied");

  // Writes happen only on accepted requests, never during a drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd.wr_en |-> (in_valid_i && !in_stall_o && !cmd.rd_en))
    else $error("store write outside an accepted request");

  // The last read of a drain returns the controller to accepting requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cmd.rd_en && cmd.rd_last) |=> (!in_stall_o && !cmd.rd_en))
    else $error("drain did not end after its last result");

  // End of sequence is only flagged on the last result of a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_data_o.sequence_end) |-> out_data_o.run_last)
    else $error("sequence end without run last");

endmodule
